// File: rtl/core/aes128_ctr_byte_cipher_unit_assert.svh
// Assertion macros used by the checker in acb_checker.sv.
`ifndef AES128_CTR_BYTE_CIPHER_UNIT_ASSERT_SVH
`define AES128_CTR_BYTE_CIPHER_UNIT_ASSERT_SVH

`define ACB_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

`define ACB_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: rtl/core/acb_pkg.sv
package acb_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned NumRoundKeys = 44;

  localparam logic [2:0] CfgKeyHigh = 3'd0;
  localparam logic [2:0] CfgKeyLow  = 3'd1;
  localparam logic [2:0] CfgIvHigh  = 3'd2;
  localparam logic [2:0] CfgIvLow   = 3'd3;
  localparam logic [2:0] CfgBypass  = 3'd4;

  localparam logic OpCipher = 1'b0;
  localparam logic OpReload = 1'b1;

  typedef logic [7:0] byte_t;

  function automatic byte_t sbox(input byte_t a);
    byte_t r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t xtime(input byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    int r, c;
    // byte n sits at bits 127-8n
    for (r = 0; r < 4; r++) begin
      for (c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    byte_t a0, a1, a2, a3, al;
    int c;
    for (c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

// File: rtl/core/aes128_ctr_byte_cipher_unit.sv
// AES-128 counter-mode byte cipher. A reload item (op 1) copies the iv
// registers into the counter and expands the key, one round-key word per
// cycle into a 44-word memory. A cipher item that needs a fresh keystream
// block (call_start, or every 16th byte) runs one shared AES round unit over
// 11 round steps; each step reads its four round-key words one at a time
// (states S_RKRD then S_ROUND per word), then the byte passes S_EMIT and
// S_OUT. Other cipher items pass S_EMIT and S_OUT, and bypass items go
// straight to S_OUT. The block accepts no item while it works or while a
// result waits in the output register.
module aes128_ctr_byte_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  input  logic        in_call_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte
);
  import acb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_KEXP  = 6'b000010,
    S_RKRD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_EMIT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t       state_r;
  logic [63:0]  key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic         bypass_r;
  logic [127:0] ctr_r, ks_r, st_r;
  logic [3:0]   pos_r;
  logic [5:0]   widx_r;
  logic [3:0]   round_r;
  logic [1:0]   col_r;
  logic [127:0] rk_r;
  logic [31:0]  rk_mem [NumRoundKeys];
  logic [31:0]  rd_r;
  logic [31:0]  w1_r, w2_r, w3_r, w4_r;
  logic [7:0]   data_r;
  logic [7:0]   out_byte_r;
  logic         out_valid_r;
  logic [7:0]   rcon_r;

  logic [31:0]  kw_nxt;
  logic [127:0] rk_nxt;
  logic [127:0] round_out;
  logic [7:0]   ks_byte;
  logic [5:0]   rd_addr;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  assign kw_nxt = w4_r ^ ((widx_r[1:0] == 2'd0)
                  ? (sub_word({w1_r[23:0], w1_r[31:24]}) ^ {rcon_r, 24'h0}) : w1_r);
  assign rd_addr = 6'({2'b00, round_r} * 6'd4 + {4'd0, col_r});
  assign rk_nxt = {rk_r[95:0], rd_r};

  always_comb begin
    round_out = st_r;
    if (round_r != 4'd0) begin
      round_out = sub_shift(st_r);
      if (round_r != 4'd10) round_out = mix_columns(round_out);
    end
    round_out = round_out ^ rk_nxt;
  end

  assign ks_byte = ks_r[127 - {pos_r, 3'b000} -: 8];

  always_ff @(posedge clk) begin
    if (state_r == S_KEXP && widx_r >= 6'd4) rk_mem[widx_r] <= kw_nxt;
    else if (state_r == S_KEXP) rk_mem[widx_r] <= w4_r;
    rd_r <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_high_r  <= '0;
      key_low_r   <= '0;
      iv_high_r   <= '0;
      iv_low_r    <= '0;
      bypass_r    <= 1'b0;
      ctr_r       <= '0;
      ks_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      widx_r      <= '0;
      round_r     <= '0;
      col_r       <= '0;
      rcon_r      <= 8'h01;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CfgKeyHigh: key_high_r <= cfg_data;
          CfgKeyLow:  key_low_r  <= cfg_data;
          CfgIvHigh:  iv_high_r  <= cfg_data;
          CfgIvLow:   iv_low_r   <= cfg_data;
          CfgBypass:  bypass_r   <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            data_r <= in_data_byte;
            if (in_op == OpReload) begin
              ctr_r  <= {iv_high_r, iv_low_r};
              pos_r  <= '0;
              widx_r <= '0;
              rcon_r <= 8'h01;
              // w4 feeds the first four words straight from the key
              w4_r <= key_high_r[63:32];
              w3_r <= key_high_r[31:0];
              w2_r <= key_low_r[63:32];
              w1_r <= key_low_r[31:0];
              state_r <= S_KEXP;
            end else if (bypass_r) begin
              out_byte_r <= in_data_byte;
              state_r    <= S_OUT;
            end else if (in_call_start || pos_r == 4'd0) begin
              pos_r   <= '0;
              st_r    <= ctr_r;
              round_r <= '0;
              col_r   <= '0;
              state_r <= S_RKRD;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_KEXP: begin
          if (widx_r < 6'd4) begin
            if (widx_r == 6'd3) begin
              w4_r <= key_high_r[63:32];
              w3_r <= key_high_r[31:0];
              w2_r <= key_low_r[63:32];
              w1_r <= key_low_r[31:0];
            end else begin
              w4_r <= w3_r;
              w3_r <= w2_r;
              w2_r <= w1_r;
            end
          end else begin
            w4_r <= w3_r;
            w3_r <= w2_r;
            w2_r <= w1_r;
            w1_r <= kw_nxt;
            if (widx_r[1:0] == 2'd0) rcon_r <= xtime(rcon_r);
          end
          if (widx_r == 6'(NumRoundKeys - 1)) state_r <= S_IDLE;
          widx_r <= widx_r + 6'd1;
        end
        S_RKRD: begin
          // read is registered; rd_r holds word at rd_addr next cycle
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          rk_r  <= rk_nxt;
          col_r <= col_r + 2'd1;
          if (col_r == 2'd3) begin
            st_r    <= round_out;
            round_r <= round_r + 4'd1;
            if (round_r == 4'd10) begin
              ks_r    <= round_out;
              ctr_r   <= ctr_r + 128'd1;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_RKRD;
            end
          end else begin
            state_r <= S_RKRD;
          end
        end
        S_EMIT: begin
          out_byte_r <= data_r ^ ks_byte;
          pos_r      <= pos_r + 4'd1;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/acb_checker.sv
module acb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte
);
`include "aes128_ctr_byte_cipher_unit_assert.svh"

  `ACB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte))
  `ACB_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `ACB_ASSERT_IMP(a_no_accept_with_out, clk, rst_n, out_valid, !in_ready)
  `ACB_ASSERT_NXT(a_out_after_accept, clk, rst_n, in_valid && in_ready, !out_valid)

endmodule

bind aes128_ctr_byte_cipher_unit acb_checker u_acb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte)
);

// File: test/ctr_keystream_checker.sv
`timescale 1ns / 1ps

module ctr_keystream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  input  logic        in_call_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  output int          fails,
  output int          pending
);
  import acb_pkg::*;

  logic [7:0]   sub_tab [256];
  logic [127:0] key_r, iv_r, ctr, ks;
  logic         byp;
  logic [3:0]   pos;
  logic [31:0]  rk [NumRoundKeys];
  logic [7:0]   expected_bytes [$];
  logic [7:0]   want;
  int           p;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  initial begin
    logic [7:0] v;
    for (int x = 0; x < 256; x++) begin
      v = 8'h01;
      for (int k = 0; k < 254; k++) v = gf_mul(v, x[7:0]);
      sub_tab[x] = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
    end
  end

  function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
    return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] t;
    logic [7:0]  rc;
    {rk[0], rk[1], rk[2], rk[3]} = key_r;
    rc = 8'h01;
    for (int i = 4; i < NumRoundKeys; i++) begin
      t = rk[i-1];
      if (i % 4 == 0) begin
        t = sub_bytes32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end
      rk[i] = rk[i-4] ^ t;
    end
  endfunction

  function automatic logic [127:0] round_key(input int r);
    return {rk[4*r], rk[4*r+1], rk[4*r+2], rk[4*r+3]};
  endfunction

  function automatic logic [127:0] sub_and_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[127 - 8*(r + 4*c) -: 8] = sub_tab[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
    return t;
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      {a0, a1, a2, a3} = s[127 - 32*c -: 32];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 32] = {a0 ^ all ^ dbl(a0 ^ a1), a1 ^ all ^ dbl(a1 ^ a2),
                             a2 ^ all ^ dbl(a2 ^ a3), a3 ^ all ^ dbl(a3 ^ a0)};
    end
    return t;
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
    logic [127:0] s;
    s = blk ^ round_key(0);
    for (int r = 1; r < 10; r++) s = mix_cols(sub_and_shift(s)) ^ round_key(r);
    return sub_and_shift(s) ^ round_key(10);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_r = '0; iv_r = '0; ctr = '0; ks = '0; byp = 1'b0; pos = '0;
      expected_bytes.delete();
      fails = 0;
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: no item expected, actual %02h", out_byte);
          fails++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want) begin
            $error("out_byte: expected %02h actual %02h", want, out_byte);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgKeyHigh: key_r[127:64] = cfg_data;
          CfgKeyLow:  key_r[63:0]   = cfg_data;
          CfgIvHigh:  iv_r[127:64]  = cfg_data;
          CfgIvLow:   iv_r[63:0]    = cfg_data;
          CfgBypass:  byp           = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_op == OpReload) begin
          ctr = iv_r;
          expand_round_keys();
          pos = '0;
        end else if (byp) begin
          expected_bytes.push_back(in_data_byte);
        end else begin
          if (in_call_start || pos == 0) begin
            pos = '0;
            ks = encrypt_block(ctr);
            ctr = ctr + 128'd1;
          end
          p = pos;
          expected_bytes.push_back(in_data_byte ^ ks[127 - 8*p -: 8]);
          pos = pos + 4'd1;
        end
      end
      pending = expected_bytes.size();
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import acb_pkg::*;

  localparam logic [2:0] CfgTopIdx = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_ready, in_op, in_call_start;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_ready;
  logic [7:0]  out_byte;
  int          fails, pending;
  bit          hold_req;

  aes128_ctr_byte_cipher_unit u_top (.*);

  ctr_keystream_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        n = 300;
      end else begin
        n = pick_gap();
      end
      if (n == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setup(input logic [127:0] key, input logic [127:0] iv,
                            input logic byp);
    write_reg(CfgKeyHigh, key[127:64]);
    write_reg(CfgKeyLow, key[63:0]);
    write_reg(CfgIvHigh, iv[127:64]);
    write_reg(CfgIvLow, iv[63:0]);
    write_reg(CfgBypass, {$urandom(), 31'($urandom()), byp});
  endtask

  task automatic send(input logic op, input logic [7:0] data, input logic start);
    int g;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_data_byte  <= data;
    in_call_start <= start;
    do @(posedge clk); while (!in_ready);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    logic op, start;
    int r;
    rst_n = 1'b0;
    hold_req = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_op = OpCipher; in_data_byte = '0; in_call_start = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_setup(128'h000102030405060708090a0b0c0d0e0f,
               128'h00112233445566778899aabbccddeeff, 1'b0);
    for (int i = CfgBypass + 1; i <= CfgTopIdx; i++) write_reg(i[2:0], '1);
    send(OpReload, 8'h00, 1'b0);
    send(OpCipher, 8'h00, 1'b1);
    send(OpCipher, 8'hff, 1'b0);
    for (int i = 0; i < 16; i++) send(OpCipher, 8'($urandom_range(0, 255)), 1'b0);
    send(OpCipher, 8'h5a, 1'b1);
    send(OpReload, 8'hff, 1'b1);
    send(OpCipher, 8'ha5, 1'b0);
    wait_idle();

    load_setup('1, '1, 1'b0);
    send(OpReload, 8'h00, 1'b0);
    for (int i = 0; i < 18; i++) send(OpCipher, 8'($urandom_range(0, 255)), i == 0);
    wait_idle();
    write_reg(CfgBypass, '1);
    send(OpCipher, 8'h00, 1'b1);
    send(OpCipher, 8'hff, 1'b0);
    send(OpReload, 8'h3c, 1'b0);
    wait_idle();
    write_reg(CfgBypass, 64'hffff_ffff_ffff_fffe);
    send(OpCipher, 8'hc3, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      load_setup({pick_word(), pick_word()}, {pick_word(), pick_word()},
                 $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0)
        write_reg(3'($urandom_range(CfgBypass + 1, CfgTopIdx)), {$urandom(), $urandom()});
      send(OpReload, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < 130; i++) begin
        r = $urandom_range(0, 99);
        op = (r < 4) ? OpReload : OpCipher;
        start = $urandom_range(0, 99) < 8;
        send(op, 8'($urandom_range(0, 255)), start);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_idle();
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: aes128_ctr_byte_cipher_unit.f
+incdir+rtl/core
rtl/core/acb_pkg.sv
rtl/core/aes128_ctr_byte_cipher_unit.sv
rtl/core/acb_checker.sv
test/ctr_keystream_checker.sv
test/tb.sv
